// ===== sv/ohlc_candle_aggregator_assert.svh =====
// Assertion macros for the candle aggregator
`ifndef OHLC_CANDLE_AGGREGATOR_ASSERT_SVH
`define OHLC_CANDLE_AGGREGATOR_ASSERT_SVH

// Implication checked every clock, off during reset
`define OHLC_ASSERT_IMPL(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("ohlc assertion failed");

// Next-cycle implication checked every clock, off during reset
`define OHLC_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("ohlc assertion failed");

`endif

// ===== sv/ohlc_pkg.sv =====
`default_nettype none
package ohlc_pkg;
    localparam int unsigned TimeW = 40;
    localparam int unsigned PriceW = 48;
    localparam int unsigned VolW = 56;
    localparam int unsigned PerW = 17;
    localparam int unsigned StatW = 3;
    localparam int unsigned EntryW = TimeW + 4 * PriceW + 2 * TimeW + VolW;

    localparam logic [StatW-1:0] ST_UPDATED = 3'd0;
    localparam logic [StatW-1:0] ST_CREATED = 3'd1;
    localparam logic [StatW-1:0] ST_FULL = 3'd2;
    localparam logic [StatW-1:0] ST_DISABLED = 3'd3;
    localparam logic [StatW-1:0] ST_CLEARED = 3'd4;

    localparam logic ACT_ADD = 1'b0;
    localparam logic ACT_CLEAR = 1'b1;

    // Classified request handed from front to back
    typedef struct packed {
        logic [StatW-1:0] kind;    // ST_UPDATED means look up, else fixed result
        logic [TimeW-1:0] bucket;
        logic [TimeW-1:0] ttime;
        logic [PriceW-1:0] price;
        logic [PriceW-1:0] amount;
    } t_req;

    typedef struct packed {
        logic [TimeW-1:0] bucket;
        logic [PriceW-1:0] open;
        logic [PriceW-1:0] high;
        logic [PriceW-1:0] low;
        logic [PriceW-1:0] close;
        logic [VolW-1:0] volume;
        logic [TimeW-1:0] open_time;
        logic [TimeW-1:0] close_time;
    } t_entry;
endpackage
`default_nettype wire

// ===== sv/ohlc_ram.sv =====
`default_nettype none
module ohlc_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 16,
    localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_waddr,
    input  wire logic [WIDTH-1:0] i_wdata,
    input  wire logic [AW-1:0]    i_raddr,
    output logic      [WIDTH-1:0] o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    // Write port and registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule
`default_nettype wire

// ===== sv/ohlc_front.sv =====
`default_nettype none
module ohlc_front
    import ohlc_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_start,
    input  wire logic              i_action,
    input  wire logic [TimeW-1:0]  i_trade_time,
    input  wire logic [PriceW-1:0] i_trade_price,
    input  wire logic [PriceW-1:0] i_trade_amount,
    input  wire logic [PerW-1:0]   i_period,
    input  wire logic              i_q_full,
    output logic                   o_busy,
    output logic                   o_push,
    output t_req                   o_req
);
    // Restoring division: one quotient bit per cycle
    typedef enum logic [1:0] {S_IDLE, S_DIV, S_PUSH} t_state;
    localparam int unsigned CntW = $clog2(TimeW + 1);

    t_state r_state;
    t_req r_req;
    logic [TimeW-1:0] r_num;
    logic [PerW-1:0] r_rem;
    logic [PerW-1:0] r_div;
    logic [CntW-1:0] r_cnt;
    logic [PerW:0] n_trial;
    logic form_bkt;

    assign n_trial = {r_rem, r_num[TimeW-1]} - {1'b0, r_div};
    // The first push cycle of a trade forms the bucket start; push only after it
    assign form_bkt = (r_state == S_PUSH) && (r_req.kind == ST_UPDATED) && (r_cnt == '0);
    assign o_busy = (r_state != S_IDLE);
    assign o_push = (r_state == S_PUSH) && !form_bkt && !i_q_full;
    assign o_req = r_req;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (i_start) begin
                        r_req.ttime <= i_trade_time;
                        r_req.price <= i_trade_price;
                        r_req.amount <= i_trade_amount;
                        r_req.bucket <= '0;
                        r_num <= i_trade_time;
                        r_rem <= '0;
                        r_div <= i_period;
                        r_cnt <= CntW'(TimeW);
                        if (i_action == ACT_CLEAR) begin
                            r_req.kind <= ST_CLEARED;
                            r_state <= S_PUSH;
                        end else if (i_period == '0) begin
                            r_req.kind <= ST_DISABLED;
                            r_state <= S_PUSH;
                        end else begin
                            r_req.kind <= ST_UPDATED;
                            r_state <= S_DIV;
                        end
                    end
                end
                S_DIV: begin
                    // shift in one numerator bit, subtract if it fits
                    r_num <= {r_num[TimeW-2:0], 1'b0};
                    if (!n_trial[PerW]) begin
                        r_rem <= n_trial[PerW-1:0];
                    end else begin
                        r_rem <= {r_rem[PerW-2:0], r_num[TimeW-1]};
                    end
                    r_cnt <= r_cnt - 1'b1;
                    if (r_cnt == CntW'(1)) begin
                        r_state <= S_PUSH;
                    end
                end
                S_PUSH: begin
                    if (form_bkt) begin
                        r_req.bucket <= r_req.ttime - TimeW'(r_rem);
                        r_cnt <= CntW'(TimeW);
                    end else if (!i_q_full) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end
endmodule
`default_nettype wire

// ===== sv/ohlc_fifo.sv =====
`default_nettype none
module ohlc_fifo
    import ohlc_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_push,
    input  t_req      i_req,
    input  wire logic i_pop,
    output logic      o_full,
    output logic      o_empty,
    output t_req      o_req
);
    // Two-entry request queue
    t_req r_slot [2];
    logic r_wp;
    logic r_rp;
    logic [1:0] r_cnt;

    assign o_full = (r_cnt == 2'd2);
    assign o_empty = (r_cnt == 2'd0);
    assign o_req = r_slot[r_rp];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_slot[r_wp] <= i_req;
        end
        if (!i_rst_n) begin
            r_wp <= 1'b0;
            r_rp <= 1'b0;
            r_cnt <= '0;
        end else begin
            if (i_push) r_wp <= ~r_wp;
            if (i_pop) r_rp <= ~r_rp;
            r_cnt <= r_cnt + {1'b0, i_push} - {1'b0, i_pop};
        end
    end
endmodule
`default_nettype wire

// ===== sv/ohlc_back.sv =====
`default_nettype none
module ohlc_back
    import ohlc_pkg::*;
#(
    parameter int unsigned TABLE_DEPTH = 64
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_empty,
    input  t_req      i_req,
    output logic      o_pop,
    output logic      o_valid,
    output logic [StatW-1:0] o_status,
    output t_entry    o_entry,
    output logic      o_idle
);
    localparam int unsigned AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int unsigned CW = $clog2(TABLE_DEPTH + 1);
    localparam logic [VolW-1:0] VolMax = '1;

    typedef enum logic [2:0] {S_IDLE, S_READ, S_CMP, S_MISS, S_UPD, S_OUT} t_state;

    t_state r_state;
    t_req r_req;
    logic [CW-1:0] r_fill;
    logic [CW-1:0] r_idx;
    logic [StatW-1:0] r_status;
    t_entry r_ent;
    logic r_valid;
    logic r_we;
    logic [AW-1:0] r_waddr;

    t_entry n_rd;
    t_entry n_upd;
    logic [VolW:0] n_sum;

    ohlc_ram #(.WIDTH(EntryW), .DEPTH(TABLE_DEPTH)) u_ram (
        .i_clk  (i_clk),
        .i_we   (r_we),
        .i_waddr(r_waddr),
        .i_wdata(r_ent),
        .i_raddr(r_idx[AW-1:0]),
        .o_rdata(n_rd)
    );

    // Merge the trade into a hit entry
    always_comb begin
        n_upd = n_rd;
        n_sum = {1'b0, n_rd.volume} + (VolW+1)'(r_req.amount);
        n_upd.volume = n_sum[VolW] ? VolMax : n_sum[VolW-1:0];
        if (r_req.price > n_rd.high) n_upd.high = r_req.price;
        if (r_req.price < n_rd.low) n_upd.low = r_req.price;
        if (r_req.ttime < n_rd.open_time) begin
            n_upd.open = r_req.price;
            n_upd.open_time = r_req.ttime;
        end
        if (r_req.ttime > n_rd.close_time) begin
            n_upd.close = r_req.price;
            n_upd.close_time = r_req.ttime;
        end
    end

    assign o_pop = (r_state == S_IDLE) && !i_empty;
    assign o_valid = r_valid;
    assign o_status = r_status;
    assign o_entry = r_ent;
    assign o_idle = (r_state == S_IDLE) && !r_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_fill <= '0;
            r_valid <= 1'b0;
            r_we <= 1'b0;
        end else begin
            // strobe the result after the output state, write after an update or a new entry
            r_valid <= (r_state == S_OUT);
            r_we <= (r_state == S_UPD) || (r_state == S_MISS && r_fill != CW'(TABLE_DEPTH));
            case (r_state)
                S_IDLE: begin
                    if (!i_empty) begin
                        r_req <= i_req;
                        r_idx <= '0;
                        r_ent <= '0;
                        if (i_req.kind == ST_CLEARED) begin
                            r_fill <= '0;
                            r_status <= ST_CLEARED;
                            r_state <= S_OUT;
                        end else if (i_req.kind == ST_DISABLED) begin
                            r_status <= ST_DISABLED;
                            r_state <= S_OUT;
                        end else begin
                            r_state <= S_READ;
                        end
                    end
                end
                S_READ: begin
                    // scan done when index reaches fill count
                    if (r_idx == r_fill) begin
                        r_state <= S_MISS;
                    end else begin
                        r_state <= S_CMP;
                    end
                end
                S_CMP: begin
                    if (n_rd.bucket == r_req.bucket) begin
                        r_state <= S_UPD;
                    end else begin
                        r_idx <= r_idx + 1'b1;
                        r_state <= S_READ;
                    end
                end
                S_UPD: begin
                    r_ent <= n_upd;
                    r_waddr <= r_idx[AW-1:0];
                    r_status <= ST_UPDATED;
                    r_state <= S_OUT;
                end
                S_MISS: begin
                    if (r_fill == CW'(TABLE_DEPTH)) begin
                        r_ent.bucket <= r_req.bucket;
                        r_status <= ST_FULL;
                    end else begin
                        r_ent <= '{bucket: r_req.bucket, open: r_req.price,
                                   high: r_req.price, low: r_req.price,
                                   close: r_req.price, volume: VolW'(r_req.amount),
                                   open_time: r_req.ttime, close_time: r_req.ttime};
                        r_waddr <= r_fill[AW-1:0];
                        r_fill <= r_fill + 1'b1;
                        r_status <= ST_CREATED;
                    end
                    r_state <= S_OUT;
                end
                S_OUT: begin
                    r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end
endmodule
`default_nettype wire

// ===== sv/ohlc_candle_aggregator.sv =====
// OHLC candle aggregator.
// Requests enter through i_start/o_busy: a request is taken at a clock edge
// where i_start is high and o_busy low. Action 0 adds a trade, action 1
// clears the table. The user must write the period register (i_cfg_we/
// i_cfg_data) only while the block is idle; the block does not enforce this.
// Zero disables aggregation. Each request yields one result, valid for
// exactly one cycle on o_valid; the receiver cannot stall, so results are
// never held back. The front divides the trade time by the period, one
// quotient bit a cycle, forms the bucket start in its push state and
// then pushes once the queue has room. The back scans the table held in
// one RAM, each entry in use through a read state and a compare state.
// The front takes no new request until it has pushed the last one, and
// holds in its push state while the two-deep queue is full.
// Reset sets the period to 300 and empties the table (fill count zero);
// no clearing pass over the RAM is needed.
`default_nettype none
`include "ohlc_candle_aggregator_assert.svh"
module ohlc_candle_aggregator
    import ohlc_pkg::*;
#(
    parameter int unsigned TABLE_DEPTH = 64
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_start,
    output logic                   o_busy,
    input  wire logic              i_action,
    input  wire logic [TimeW-1:0]  i_trade_time,
    input  wire logic [PriceW-1:0] i_trade_price,
    input  wire logic [PriceW-1:0] i_trade_amount,
    input  wire logic              i_cfg_we,
    input  wire logic [PerW-1:0]   i_cfg_data,
    output logic                   o_valid,
    output logic [StatW-1:0]       o_status,
    output logic [TimeW-1:0]       o_bucket_start,
    output logic [PriceW-1:0]      o_open_price,
    output logic [PriceW-1:0]      o_high_price,
    output logic [PriceW-1:0]      o_low_price,
    output logic [PriceW-1:0]      o_close_price,
    output logic [VolW-1:0]        o_volume,
    output logic [TimeW-1:0]       o_first_time,
    output logic [TimeW-1:0]       o_last_time
);
    logic [PerW-1:0] r_period;
    logic q_full, q_empty, push, pop, back_idle;
    t_req f_req, q_req;
    t_entry ent;

    // Hold the period register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_period <= PerW'(300);
        end else if (i_cfg_we) begin
            r_period <= i_cfg_data;
        end
    end

    ohlc_front u_front (
        .i_clk, .i_rst_n, .i_start, .i_action, .i_trade_time, .i_trade_price,
        .i_trade_amount, .i_period(r_period), .i_q_full(q_full),
        .o_busy, .o_push(push), .o_req(f_req)
    );

    ohlc_fifo u_fifo (
        .i_clk, .i_rst_n, .i_push(push), .i_req(f_req), .i_pop(pop),
        .o_full(q_full), .o_empty(q_empty), .o_req(q_req)
    );

    ohlc_back #(.TABLE_DEPTH(TABLE_DEPTH)) u_back (
        .i_clk, .i_rst_n, .i_empty(q_empty), .i_req(q_req), .o_pop(pop),
        .o_valid, .o_status, .o_entry(ent), .o_idle(back_idle)
    );

    assign o_bucket_start = ent.bucket;
    assign o_open_price = ent.open;
    assign o_high_price = ent.high;
    assign o_low_price = ent.low;
    assign o_close_price = ent.close;
    assign o_volume = ent.volume;
    assign o_first_time = ent.open_time;
    assign o_last_time = ent.close_time;

    `OHLC_ASSERT_IMPL(a_no_pop_empty, pop, !q_empty)
    `OHLC_ASSERT_IMPL(a_no_push_full, push, !q_full)
    `OHLC_ASSERT_IMPL(a_clear_zero, o_valid && o_status == ST_CLEARED, o_volume == '0)
    `OHLC_ASSERT_NEXT(a_start_busy, i_start && !o_busy, o_busy)
    `OHLC_ASSERT_IMPL(a_idle_valid, o_valid, !back_idle)
endmodule
`default_nettype wire
